### src/lasc_pkg.sv
package lasc_pkg;

  localparam int COORD_W   = 12;
  localparam int SRC_DIM_W = 13;
  localparam int CH_W      = 8;
  localparam int RGB_W     = 3 * CH_W;
  localparam int DIV_W     = 32;
  localparam int QDEPTH    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd3;

  localparam logic REQ_LOAD = 1'b0;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_QUERY,
    KIND_BLACK
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t        kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RGB_W-1:0]   rgb;
  } q_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP,
    S_FIT,
    S_FIT_WAIT,
    S_OFS,
    S_BOX,
    S_BOX_WAIT,
    S_BOX_ADJ,
    S_RD,
    S_ACC,
    S_CNT,
    S_AVG,
    S_AVG_WAIT,
    S_EMIT
  } back_state_t;

endpackage

### src/lasc_ram.sv
module lasc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/lasc_div.sv
module lasc_div import lasc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quot
);
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]     rem;
  logic [DIV_W-1:0]   divisor;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DIV_W:0]     trial;

  assign trial = {rem[DIV_W-1:0], quot[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(DIV_W);
        rem     <= '0;
        quot    <= num;
        divisor <= den;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem  <= trial - {1'b0, divisor};
          quot <= {quot[DIV_W-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### src/lasc_front.sv
module lasc_front import lasc_pkg::*; #(
  parameter int MAX_SRC_W = 1024,
  parameter int MAX_SRC_H = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [COORD_W-1:0]   coord_x,
  input  logic [COORD_W-1:0]   coord_y,
  input  logic [RGB_W-1:0]     rgb,
  input  logic [COORD_W-1:0]   cw,
  input  logic [COORD_W-1:0]   ch,
  output logic                 q_valid,
  output q_entry_t             q_head,
  input  logic                 q_pop
);
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_entry_t          mem [QDEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              keep;
  logic              push;
  q_entry_t          entry;

  always_comb begin
    entry.x   = coord_x;
    entry.y   = coord_y;
    entry.rgb = rgb;
    keep      = 1'b1;
    if (req_type == REQ_LOAD) begin
      entry.kind = KIND_LOAD;
      keep = (32'(coord_x) < MAX_SRC_W) && (32'(coord_y) < MAX_SRC_H);
    end else if ((coord_x >= cw) || (coord_y >= ch)) begin
      entry.kind = KIND_BLACK;
    end else begin
      entry.kind = KIND_QUERY;
    end
  end

  assign in_stall = (count == CW'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != '0);
  assign q_head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= entry;
        wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(q_pop);
    end
  end
endmodule

### src/lasc_back.sv
module lasc_back import lasc_pkg::*; #(
  parameter int MAX_SRC_W = 1024,
  parameter int MAX_SRC_H = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  q_entry_t             q_head,
  output logic                 q_pop,
  input  logic [SRC_DIM_W-1:0] sw,
  input  logic [SRC_DIM_W-1:0] sh,
  input  logic [COORD_W-1:0]   cw,
  input  logic [COORD_W-1:0]   ch,
  output logic                 ram_we,
  output logic [((MAX_SRC_W * MAX_SRC_H > 1) ? $clog2(MAX_SRC_W * MAX_SRC_H) : 1)-1:0]
                               ram_waddr,
  output logic [RGB_W-1:0]     ram_wdata,
  output logic [((MAX_SRC_W * MAX_SRC_H > 1) ? $clog2(MAX_SRC_W * MAX_SRC_H) : 1)-1:0]
                               ram_raddr,
  input  logic [RGB_W-1:0]     ram_rdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CH_W-1:0]      out_red,
  output logic [CH_W-1:0]      out_green,
  output logic [CH_W-1:0]      out_blue,
  output logic                 in_picture
);
  localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = COORD_W + SRC_DIM_W;
  localparam int BP_W   = 2 * SRC_DIM_W;

  back_state_t state, state_next;

  logic                 div_start;
  logic [DIV_W-1:0]     div_num;
  logic [DIV_W-1:0]     div_den;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;

  logic [COORD_W-1:0]   qx, qy;
  logic [PROD_W-1:0]    prod_a, prod_b;
  logic                 wide;
  logic [COORD_W-1:0]   dw, dh, dx, dy;
  logic [SRC_DIM_W-1:0] sy0, sy1, sx0, sx1, cy, cx;
  logic [DIV_W-1:0]     sum_r, sum_g, sum_b, npix;
  logic [1:0]           k;
  logic [CH_W-1:0]      res_r, res_g, res_b;
  logic                 res_in;

  logic [COORD_W-1:0]   fit;
  logic [COORD_W-1:0]   x0, y0;
  logic                 in_box;
  logic                 out_free;
  logic [SRC_DIM_W-1:0] box_d;
  logic [SRC_DIM_W-1:0] box_s;
  logic [DIV_W-1:0]     avg_sum;

  lasc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_free = !out_valid || !out_stall;
  assign fit = (div_quot[COORD_W-1:0] == '0) ? COORD_W'(1) : div_quot[COORD_W-1:0];
  assign x0 = (cw - dw) >> 1;
  assign y0 = (ch - dh) >> 1;
  assign in_box = (qx >= x0) && (qy >= y0) && ((qx - x0) < dw) && ((qy - y0) < dh);
  assign box_d = k[1] ? SRC_DIM_W'(dx) + SRC_DIM_W'(k[0]) : SRC_DIM_W'(dy) + SRC_DIM_W'(k[0]);
  assign box_s = k[1] ? sw : sh;

  always_comb begin
    case (k)
      2'd0:    avg_sum = sum_r;
      2'd1:    avg_sum = sum_g;
      default: avg_sum = sum_b;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_head.kind)
            KIND_QUERY: state_next = S_CMP;
            KIND_BLACK: state_next = S_EMIT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_CMP:      state_next = S_FIT;
      S_FIT:      state_next = S_FIT_WAIT;
      S_FIT_WAIT: if (div_done) state_next = S_OFS;
      S_OFS:      state_next = in_box ? S_BOX : S_EMIT;
      S_BOX:      state_next = S_BOX_WAIT;
      S_BOX_WAIT: if (div_done) state_next = (k == 2'd3) ? S_BOX_ADJ : S_BOX;
      S_BOX_ADJ:  state_next = S_RD;
      S_RD:       state_next = S_ACC;
      S_ACC: begin
        if ((cx + 1'b1 < sx1) || (cy + 1'b1 < sy1)) begin
          state_next = S_RD;
        end else begin
          state_next = S_CNT;
        end
      end
      S_CNT:      state_next = S_AVG;
      S_AVG:      state_next = S_AVG_WAIT;
      S_AVG_WAIT: if (div_done) state_next = (k == 2'd2) ? S_EMIT : S_AVG;
      S_EMIT:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(32'(q_head.y) * MAX_SRC_W + 32'(q_head.x));
    ram_wdata = q_head.rgb;
    ram_raddr = AW'(32'(cy) * MAX_SRC_W + 32'(cx));
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && (q_head.kind == KIND_LOAD);
      end
      S_FIT: begin
        div_start = 1'b1;
        if (prod_a <= prod_b) begin
          div_num = DIV_W'({prod_a, 1'b0}) + DIV_W'(sw);
          div_den = DIV_W'({sw, 1'b0});
        end else begin
          div_num = DIV_W'({prod_b, 1'b0}) + DIV_W'(sh);
          div_den = DIV_W'({sh, 1'b0});
        end
      end
      S_BOX: begin
        div_start = 1'b1;
        div_num   = DIV_W'(BP_W'(box_d) * BP_W'(box_s));
        div_den   = DIV_W'(k[1] ? dw : dh);
      end
      S_AVG: begin
        div_start = 1'b1;
        div_num   = avg_sum;
        div_den   = npix;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_red    <= res_r;
      out_green  <= res_g;
      out_blue   <= res_b;
      in_picture <= res_in;
    end
    case (state)
      S_IDLE: begin
        qx     <= q_head.x;
        qy     <= q_head.y;
        res_r  <= '0;
        res_g  <= '0;
        res_b  <= '0;
        res_in <= 1'b0;
      end
      S_CMP: begin
        prod_a <= PROD_W'(cw) * PROD_W'(sh);
        prod_b <= PROD_W'(ch) * PROD_W'(sw);
      end
      S_FIT: wide <= (prod_a <= prod_b);
      S_FIT_WAIT: begin
        if (div_done) begin
          dw <= wide ? cw : fit;
          dh <= wide ? fit : ch;
        end
      end
      S_OFS: begin
        dx <= qx - x0;
        dy <= qy - y0;
        k  <= 2'd0;
      end
      S_BOX_WAIT: begin
        if (div_done) begin
          case (k)
            2'd0:    sy0 <= div_quot[SRC_DIM_W-1:0];
            2'd1:    sy1 <= div_quot[SRC_DIM_W-1:0];
            2'd2:    sx0 <= div_quot[SRC_DIM_W-1:0];
            default: sx1 <= div_quot[SRC_DIM_W-1:0];
          endcase
          k <= k + 1'b1;
        end
      end
      S_BOX_ADJ: begin
        if (sy1 <= sy0) sy1 <= sy0 + 1'b1;
        if (sx1 <= sx0) sx1 <= sx0 + 1'b1;
        cy    <= sy0;
        cx    <= sx0;
        sum_r <= '0;
        sum_g <= '0;
        sum_b <= '0;
      end
      S_ACC: begin
        sum_r <= sum_r + DIV_W'(ram_rdata[3*CH_W-1:2*CH_W]);
        sum_g <= sum_g + DIV_W'(ram_rdata[2*CH_W-1:CH_W]);
        sum_b <= sum_b + DIV_W'(ram_rdata[CH_W-1:0]);
        if (cx + 1'b1 < sx1) begin
          cx <= cx + 1'b1;
        end else begin
          cx <= sx0;
          cy <= cy + 1'b1;
        end
      end
      S_CNT: begin
        npix <= DIV_W'(BP_W'(sy1 - sy0) * BP_W'(sx1 - sx0));
        k    <= 2'd0;
      end
      S_AVG_WAIT: begin
        if (div_done) begin
          case (k)
            2'd0:    res_r <= div_quot[CH_W-1:0];
            2'd1:    res_g <= div_quot[CH_W-1:0];
            default: begin
              res_b  <= div_quot[CH_W-1:0];
              res_in <= 1'b1;
            end
          endcase
          k <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

### src/letterbox_area_average_scaler.sv
// Fits a stored source frame into a canvas with its aspect ratio kept, centered, and answers
// canvas pixel queries with the truncated mean of the covering source box (black in margins).
// A load transaction writes one pixel and is retired by the execution side in its idle state. A
// query runs on one shared 32-step serial divider: one division for the fitted size, four for
// the box edges and three for the channel means. An answered query inside the picture also
// spends, for each source pixel in the box, one frame store read and one accumulate; a query in
// a margin skips the box and mean divisions, and one outside the canvas skips the divider.
// Output stalls hold the result back. A two-entry queue lets new transactions be taken while a
// query is being worked on. The frame store is not cleared; pixels must be loaded before use.
module letterbox_area_average_scaler import lasc_pkg::*; #(
  parameter int MAX_SRC_W = 1024,
  parameter int MAX_SRC_H = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [COORD_W-1:0]   coord_x,
  input  logic [COORD_W-1:0]   coord_y,
  input  logic [CH_W-1:0]      in_red,
  input  logic [CH_W-1:0]      in_green,
  input  logic [CH_W-1:0]      in_blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CH_W-1:0]      out_red,
  output logic [CH_W-1:0]      out_green,
  output logic [CH_W-1:0]      out_blue,
  output logic                 in_picture
);
  localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [10:0]          source_width, source_height;
  logic [COORD_W-1:0]   canvas_width, canvas_height;
  logic [SRC_DIM_W-1:0] sw, sh;

  logic                 q_valid, q_pop;
  q_entry_t             q_head;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [RGB_W-1:0]     ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 11'd1024;
      source_height <= 11'd1024;
      canvas_width  <= 12'd1920;
      canvas_height <= 12'd1080;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[10:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[10:0];
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (source_width == '0) begin
      sw = SRC_DIM_W'(1);
    end else if (32'(source_width) > MAX_SRC_W) begin
      sw = SRC_DIM_W'(MAX_SRC_W);
    end else begin
      sw = SRC_DIM_W'(source_width);
    end
    if (source_height == '0) begin
      sh = SRC_DIM_W'(1);
    end else if (32'(source_height) > MAX_SRC_H) begin
      sh = SRC_DIM_W'(MAX_SRC_H);
    end else begin
      sh = SRC_DIM_W'(source_height);
    end
  end

  lasc_front #(
    .MAX_SRC_W (MAX_SRC_W),
    .MAX_SRC_H (MAX_SRC_H)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .rgb      ({in_red, in_green, in_blue}),
    .cw       (canvas_width),
    .ch       (canvas_height),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  lasc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lasc_back #(
    .MAX_SRC_W (MAX_SRC_W),
    .MAX_SRC_H (MAX_SRC_H)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .sw         (sw),
    .sh         (sh),
    .cw         (canvas_width),
    .ch         (canvas_height),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .in_picture (in_picture)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_write_only_on_pop: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> q_pop) else $error("frame store written outside a load");

  a_margin_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_picture) |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("margin result is not black");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result pending after reset");

endmodule
